[design/hhmm_pkg.sv]
`default_nettype none

package hhmm_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_SECOND_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_PERIOD     = 2'd2;

  // Register reset values
  localparam logic [9:0] HALF_SECOND_TICKS_RST = 10'd200;
  localparam logic [7:0] REPEAT_DELAY_RST      = 8'd50;
  localparam logic [5:0] REPEAT_PERIOD_RST     = 6'd10;

  // Time limits
  localparam logic [4:0] HOUR_MAX     = 5'd23;
  localparam logic [5:0] MINUTE_MAX   = 6'd59;
  localparam logic [5:0] SECOND_WRAP  = 6'd60;

  // Input word kinds
  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
  } hhmm_time_t;

  // One minute forward, carrying into the hour
  function automatic hhmm_time_t step_up(hhmm_time_t t);
    hhmm_time_t r;
    r = t;
    if (t.minutes >= MINUTE_MAX) begin
      r.minutes = '0;
      r.hours   = (t.hours >= HOUR_MAX) ? 5'd0 : t.hours + 5'd1;
    end else begin
      r.minutes = t.minutes + 6'd1;
    end
    return r;
  endfunction

  // One minute back, borrowing from the hour
  function automatic hhmm_time_t step_down(hhmm_time_t t);
    hhmm_time_t r;
    r = t;
    if (t.minutes == 6'd0) begin
      r.minutes = MINUTE_MAX;
      r.hours   = (t.hours == 5'd0) ? HOUR_MAX : t.hours - 5'd1;
    end else begin
      r.minutes = t.minutes - 6'd1;
    end
    return r;
  endfunction

  // Tens digit of a value below 64
  function automatic logic [2:0] digit_tens(logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  // Units digit, given the tens digit
  function automatic logic [3:0] digit_units(logic [5:0] v, logic [2:0] tens);
    logic [5:0] d;
    d = v - ({3'b000, tens} * 6'd10);
    return d[3:0];
  endfunction

  // Segment pattern a..g, bit6 = a
  function automatic logic [6:0] seg_decode(logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'h7E;
      4'd1:    s = 7'h30;
      4'd2:    s = 7'h6D;
      4'd3:    s = 7'h79;
      4'd4:    s = 7'h33;
      4'd5:    s = 7'h5B;
      4'd6:    s = 7'h5F;
      4'd7:    s = 7'h70;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h7B;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[design/hhmm_clock_with_set_buttons.sv]
`default_nettype none

// Channel | Direction | Handshake           | Word
// in_     | input     | in_valid/in_ready   | req_type, btn_up, btn_down
// out_    | output    | out_valid/out_ready | segments, digit_enable, led, hours,
//         |           |                     | minutes, time_set
// cfg_    | input     | cfg_valid/cfg_ready | index (2 bits), data (10 bits)
//
// One word per clock while in_ready is high: all state updates in the cycle a
// word is accepted, and the result sits in the output register the next cycle.
// A new word is taken while a result waits, as long as out_ready is high.
// A write to repeat_period starts a remainder recompute of both hold
// counters; in_ready and cfg_ready stay low while it runs.
// Synchronous active-low reset; the clock starts at 00:00, unset and blinking.

module hhmm_clock_with_set_buttons (
  input  wire                               clk,
  input  wire                               rst_n,
  // input channel
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               in_req_type,
  input  wire                               in_btn_up,
  input  wire                               in_btn_down,
  // result channel
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [6:0]                        out_segments,
  output logic [3:0]                        out_digit_enable,
  output logic                              out_led,
  output logic [4:0]                        out_hours,
  output logic [5:0]                        out_minutes,
  output logic                              out_time_set,
  // configuration
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [hhmm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [hhmm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers
  logic [9:0] half_ticks_r;
  logic [7:0] rpt_delay_r;
  logic [5:0] rpt_period_r;

  // Clock state
  hhmm_pkg::hhmm_time_t time_r, time_nxt;
  logic [5:0] second_r, second_nxt;
  logic [9:0] tick_r, tick_nxt;
  logic       half_phase_r, half_phase_nxt;
  logic       led_r, led_nxt;
  logic       visible_r, visible_nxt;
  logic       set_r, set_nxt;
  logic [1:0] digit_r, digit_nxt;

  // Button hold counters and their remainders modulo the period
  logic [8:0] up_cnt_r, up_cnt_nxt;
  logic [8:0] dn_cnt_r, dn_cnt_nxt;
  logic [6:0] up_rem_r, up_rem_nxt;
  logic [6:0] dn_rem_r, dn_rem_nxt;

  // Remainder recompute sequencer
  logic       busy_r, busy_nxt;
  logic [3:0] div_bit_r, div_bit_nxt;

  // Output register
  logic       out_valid_r;
  logic [6:0] seg_r, seg_nxt;
  logic [3:0] en_r, en_nxt;

  logic in_acc, cfg_acc;
  logic [5:0] eff_period;
  logic [9:0] eff_half;

  assign in_ready  = !busy_r && (!out_valid_r || out_ready);
  assign cfg_ready = !busy_r;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign eff_period = (rpt_period_r == 6'd0) ? 6'd1 : rpt_period_r;
  assign eff_half   = (half_ticks_r == 10'd0) ? 10'd1 : half_ticks_r;

  // Per-button hold update: next count, next remainder, first press, repeat step
  typedef struct packed {
    logic [8:0] cnt;
    logic [6:0] rem;
    logic       first;
    logic       rpt;
  } hold_upd_t;

  function automatic hold_upd_t hold_update(logic [8:0] cnt, logic [6:0] rem,
                                            logic pressed, logic [7:0] dly,
                                            logic [5:0] per);
    hold_upd_t  u;
    logic [9:0] c1;
    logic [6:0] r1;
    u  = '0;
    c1 = {1'b0, cnt} + 10'd1;
    r1 = (rem + 7'd1 >= {1'b0, per}) ? 7'd0 : rem + 7'd1;
    if (pressed) begin
      u.first = (c1 == 10'd1);
      u.rpt   = (c1 > {2'b00, dly}) && (r1 == 7'd0);
      u.rem   = r1;
      if (c1 > ({2'b00, dly} + {4'b0000, per}))
        u.cnt = 9'(c1 - {4'b0000, per});
      else
        u.cnt = c1[8:0];
    end
    return u;
  endfunction

  hold_upd_t up_u, dn_u;
  hhmm_pkg::hhmm_time_t t_a, t_b, t_c, t_d;
  logic [2:0] h_tens, m_tens;
  logic [3:0] digit_val;
  logic [9:0] tick_inc;
  logic [5:0] sec_inc;
  logic [6:0] up_shift, dn_shift;

  assign up_u = hold_update(up_cnt_r, up_rem_r, in_btn_up,   rpt_delay_r, eff_period);
  assign dn_u = hold_update(dn_cnt_r, dn_rem_r, in_btn_down, rpt_delay_r, eff_period);

  // Digit value for the current scan position
  always_comb begin
    h_tens = hhmm_pkg::digit_tens({1'b0, time_r.hours});
    m_tens = hhmm_pkg::digit_tens(time_r.minutes);
    unique case (digit_r)
      2'd0:    digit_val = {1'b0, h_tens};
      2'd1:    digit_val = hhmm_pkg::digit_units({1'b0, time_r.hours}, h_tens);
      2'd2:    digit_val = {1'b0, m_tens};
      default: digit_val = hhmm_pkg::digit_units(time_r.minutes, m_tens);
    endcase
  end

  // Next state and result for one accepted word
  always_comb begin
    time_nxt       = time_r;
    second_nxt     = second_r;
    tick_nxt       = tick_r;
    half_phase_nxt = half_phase_r;
    led_nxt        = led_r;
    visible_nxt    = visible_r;
    set_nxt        = set_r;
    digit_nxt      = digit_r;
    up_cnt_nxt     = up_cnt_r;
    dn_cnt_nxt     = dn_cnt_r;
    up_rem_nxt     = up_rem_r;
    dn_rem_nxt     = dn_rem_r;
    seg_nxt        = 7'd0;
    en_nxt         = 4'd0;
    tick_inc       = tick_r + 10'd1;
    sec_inc        = second_r + 6'd1;
    t_a            = time_r;
    t_b            = time_r;
    t_c            = time_r;
    t_d            = time_r;

    if (in_acc) begin
      if (in_req_type == hhmm_pkg::REQ_SCAN) begin
        // display scan tick
        if (visible_r) begin
          seg_nxt = hhmm_pkg::seg_decode(digit_val);
          en_nxt  = 4'b1000 >> digit_r;
        end
        digit_nxt = digit_r + 2'd1;
        tick_nxt  = tick_inc;
        if (tick_inc >= eff_half) begin
          tick_nxt       = '0;
          half_phase_nxt = !half_phase_r;
          led_nxt        = !led_r;
          if (!set_r) begin
            visible_nxt = !half_phase_r;
          end else begin
            visible_nxt = 1'b1;
            if (half_phase_r) begin
              if (sec_inc >= hhmm_pkg::SECOND_WRAP) begin
                second_nxt = '0;
                time_nxt   = hhmm_pkg::step_up(time_r);
              end else begin
                second_nxt = sec_inc;
              end
            end
          end
        end
      end else begin
        // button poll: up first, then down
        t_a = up_u.first ? hhmm_pkg::step_up(time_r) : time_r;
        t_b = up_u.rpt   ? hhmm_pkg::step_up(t_a) : t_a;
        t_c = dn_u.first ? hhmm_pkg::step_down(t_b) : t_b;
        t_d = dn_u.rpt   ? hhmm_pkg::step_down(t_c) : t_c;
        time_nxt   = t_d;
        up_cnt_nxt = up_u.cnt;
        dn_cnt_nxt = dn_u.cnt;
        up_rem_nxt = up_u.rem;
        dn_rem_nxt = dn_u.rem;
        if (up_u.first || dn_u.first) begin
          set_nxt     = 1'b1;
          visible_nxt = 1'b1;
        end
      end
    end
  end

  // Remainder recompute after a period change, one count bit per cycle, MSB first
  always_comb begin
    busy_nxt    = busy_r;
    div_bit_nxt = div_bit_r;
    up_shift    = {up_rem_r[5:0], up_cnt_r[div_bit_r]};
    dn_shift    = {dn_rem_r[5:0], dn_cnt_r[div_bit_r]};
    if (busy_r) begin
      div_bit_nxt = (div_bit_r == 4'd0) ? 4'd0 : div_bit_r - 4'd1;
      busy_nxt    = (div_bit_r != 4'd0);
    end else if (cfg_acc && cfg_index == hhmm_pkg::REG_REPEAT_PERIOD) begin
      busy_nxt    = 1'b1;
      div_bit_nxt = 4'd8;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_ticks_r <= hhmm_pkg::HALF_SECOND_TICKS_RST;
      rpt_delay_r  <= hhmm_pkg::REPEAT_DELAY_RST;
      rpt_period_r <= hhmm_pkg::REPEAT_PERIOD_RST;
      time_r       <= '0;
      second_r     <= '0;
      tick_r       <= '0;
      half_phase_r <= 1'b0;
      led_r        <= 1'b1;
      visible_r    <= 1'b1;
      set_r        <= 1'b0;
      digit_r      <= '0;
      up_cnt_r     <= '0;
      dn_cnt_r     <= '0;
      up_rem_r     <= '0;
      dn_rem_r     <= '0;
      busy_r       <= 1'b0;
      div_bit_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index)
          hhmm_pkg::REG_HALF_SECOND_TICKS: half_ticks_r <= cfg_data[9:0];
          hhmm_pkg::REG_REPEAT_DELAY:      rpt_delay_r  <= cfg_data[7:0];
          hhmm_pkg::REG_REPEAT_PERIOD:     rpt_period_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      time_r       <= time_nxt;
      second_r     <= second_nxt;
      tick_r       <= tick_nxt;
      half_phase_r <= half_phase_nxt;
      led_r        <= led_nxt;
      visible_r    <= visible_nxt;
      set_r        <= set_nxt;
      digit_r      <= digit_nxt;
      up_cnt_r     <= up_cnt_nxt;
      dn_cnt_r     <= dn_cnt_nxt;
      busy_r       <= busy_nxt;
      div_bit_r    <= div_bit_nxt;
      // remainders: cleared at recompute start, restoring steps while busy
      if (busy_r) begin
        up_rem_r <= (up_shift >= {1'b0, eff_period}) ? up_shift - {1'b0, eff_period}
                                                     : up_shift;
        dn_rem_r <= (dn_shift >= {1'b0, eff_period}) ? dn_shift - {1'b0, eff_period}
                                                     : dn_shift;
      end else if (busy_nxt) begin
        up_rem_r <= '0;
        dn_rem_r <= '0;
      end else begin
        up_rem_r <= up_rem_nxt;
        dn_rem_r <= dn_rem_nxt;
      end
      if (in_acc)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      seg_r <= seg_nxt;
      en_r  <= en_nxt;
    end
  end

  logic       led_o_r, set_o_r;
  logic [4:0] hours_o_r;
  logic [5:0] minutes_o_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      led_o_r     <= led_nxt;
      set_o_r     <= set_nxt;
      hours_o_r   <= time_nxt.hours;
      minutes_o_r <= time_nxt.minutes;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_segments     = seg_r;
  assign out_digit_enable = en_r;
  assign out_led          = led_o_r;
  assign out_hours        = hours_o_r;
  assign out_minutes      = minutes_o_r;
  assign out_time_set     = set_o_r;

  // Checks
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (!in_ready && !cfg_ready))
    else $error("word or write taken during remainder recompute");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (time_r.hours <= hhmm_pkg::HOUR_MAX) && (time_r.minutes <= hhmm_pkg::MINUTE_MAX)
    && (second_r < hhmm_pkg::SECOND_WRAP))
    else $error("time counters out of range");

  a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> ((up_rem_r < {1'b0, eff_period}) && (dn_rem_r < {1'b0, eff_period})))
    else $error("hold remainder not below repeat period");

  a_poll_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req_type == hhmm_pkg::REQ_POLL) |=> (en_r == 4'd0 && seg_r == 7'd0))
    else $error("poll result lights a digit");

  a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(en_r))
    else $error("more than one digit enabled");

endmodule

`default_nettype wire
